// ===== rtl/acs_pkg.sv =====
// Shared constants, codes and the memory preset table of the accumulator processor.
package acs_pkg;

  // Architectural widths
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned ACC_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W   = 4;

  // Byte memory, a power of two from 256 to 4096 bytes
  localparam int unsigned MEM_DEPTH = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  // Input word kinds; the fourth code is unused and changes nothing
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_STEP  = 2'd2
  } action_e;

  // Instruction opcodes; the codes not listed only advance the program counter
  typedef enum logic [OP_W-1:0] {
    OP_JMP   = 4'd0,
    OP_JZ    = 4'd1,
    OP_JN    = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_DIV   = 4'd6,
    OP_LOAD  = 4'd7,
    OP_STORE = 4'd8,
    OP_CALL  = 4'd9,
    OP_RET   = 4'd10,
    OP_STOP  = 4'd13
  } opcode_e;

  // Memory bytes that come up non-zero after reset
  localparam logic [MEM_AW-1:0] PRESET_ADDR_A = MEM_AW'(8'h0a);
  localparam logic [MEM_AW-1:0] PRESET_ADDR_B = MEM_AW'(8'h1a);
  localparam logic [MEM_AW-1:0] PRESET_ADDR_C = MEM_AW'(8'h21);
  localparam logic [MEM_AW-1:0] PRESET_ADDR_D = MEM_AW'(8'h3F);
  localparam logic [BYTE_W-1:0] PRESET_BYTE_A = 8'h01;
  localparam logic [BYTE_W-1:0] PRESET_BYTE_B = 8'h12;
  localparam logic [BYTE_W-1:0] PRESET_BYTE_C = 8'h42;
  localparam logic [BYTE_W-1:0] PRESET_BYTE_D = 8'h20;

  // Reset contents of one memory byte
  function automatic logic [BYTE_W-1:0] mem_init_byte(input logic [MEM_AW-1:0] a);
    logic [BYTE_W-1:0] b;
    case (a)
      PRESET_ADDR_A: b = PRESET_BYTE_A;
      PRESET_ADDR_B: b = PRESET_BYTE_B;
      PRESET_ADDR_C: b = PRESET_BYTE_C;
      PRESET_ADDR_D: b = PRESET_BYTE_D;
      default:       b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/acs_div.sv =====
// Iterative signed 16-bit divider, one quotient bit per cycle, truncating toward zero.
module acs_div
  import acs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] dividend_i,
  input  logic [ACC_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [ACC_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(ACC_W);

  logic             busy_q;
  logic             done_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W:0]   rem_q;
  logic [ACC_W-1:0] quo_q;
  logic [ACC_W-1:0] mag_b_q;

  logic [ACC_W-1:0] mag_a;
  logic [ACC_W-1:0] mag_b;
  logic [ACC_W:0]   rem_shift;
  logic [ACC_W:0]   rem_diff;

  // Take magnitudes of the operands
  assign mag_a = dividend_i[ACC_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b = divisor_i[ACC_W-1] ? (~divisor_i + 1'b1) : divisor_i;

  // One restoring step: shift in the next dividend bit and try the subtract
  assign rem_shift = {rem_q[ACC_W-1:0], quo_q[ACC_W-1]};
  assign rem_diff  = rem_shift - {1'b0, mag_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      mag_b_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        neg_q   <= dividend_i[ACC_W-1] ^ divisor_i[ACC_W-1];
        cnt_q   <= CNT_W'(ACC_W - 1);
        rem_q   <= '0;
        quo_q   <= mag_a;
        mag_b_q <= mag_b;
      end else if (busy_q) begin
        if (rem_diff[ACC_W]) begin
          rem_q <= rem_shift;
          quo_q <= {quo_q[ACC_W-2:0], 1'b0};
        end else begin
          rem_q <= rem_diff;
          quo_q <= {quo_q[ACC_W-2:0], 1'b1};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Apply the sign; wraps to 16 bits for the most negative dividend over minus one
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/accumulator_cpu_step.sv =====
// Top level of the accumulator processor: byte memory, step sequencer and result register.
//
// A small accumulator processor with a byte-wide memory and a 16-bit accumulator. Each input
// word writes one memory byte, sets the program counter (and clears the link register), or
// executes one two-byte instruction; every input word returns one result word with the program
// counter, accumulator, stop flag of the byte at the program counter, the opcode executed and
// the divide-by-zero flag. All memory traffic goes through one byte-wide port with a registered
// read, one access per cycle, and that port sets the timing: a step makes two fetch reads, two
// operand reads and one read of the next opcode before it loads the result register; a store
// adds a state for its second byte write, a divide waits on the bit-serial divider, and write,
// start and stopped-step words read the byte at the program counter before the result is loaded.
// The next word can be taken in the cycle after the result is loaded. One word is in work at a
// time; the result register lets the next word be accepted while the previous result waits.
// After reset the block sweeps the memory to its preset contents, one byte per cycle, before it
// accepts the first word.
module accumulator_cpu_step
  import acs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [ADDR_W-1:0]       address_i,
  input  logic [BYTE_W-1:0]       data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ADDR_W-1:0]       pc_o,
  output logic signed [ACC_W-1:0] acc_value_o,
  output logic                    halted_o,
  output logic [OP_W-1:0]         executed_opcode_o,
  output logic                    div_error_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F0,
    ST_F1,
    ST_OP0,
    ST_OP1,
    ST_ST1,
    ST_DIV,
    ST_HALT_RD,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [MEM_AW-1:0]   clr_cnt_q;
  logic [ADDR_W-1:0]   pc_q;
  logic [ACC_W-1:0]    acc_q;
  logic [ADDR_W-1:0]   link_q;
  logic [BYTE_W-1:0]   b0_q;
  logic [ADDR_W-1:0]   arg_q;
  logic [BYTE_W-1:0]   opnd_hi_q;
  logic [OP_W-1:0]     exec_op_q;
  logic                div_err_q;

  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_pc_q;
  logic [ACC_W-1:0]    out_acc_q;
  logic                out_halted_q;
  logic [OP_W-1:0]     out_op_q;
  logic                out_div_err_q;

  logic [BYTE_W-1:0]   mem_q [MEM_DEPTH];
  logic [BYTE_W-1:0]   rd_q;

  logic [ADDR_W-1:0]   mem_addr;
  logic [MEM_AW-1:0]   mem_idx;
  logic                mem_we;
  logic [BYTE_W-1:0]   mem_wdata;

  logic [OP_W-1:0]     op;
  logic [ACC_W-1:0]    opnd;
  logic [ADDR_W-1:0]   pc_plus2;
  logic [ACC_W-1:0]    product;

  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [ACC_W-1:0]    div_quotient;

  assign op       = b0_q[BYTE_W-1:BYTE_W-OP_W];
  assign opnd     = {opnd_hi_q, rd_q};
  assign pc_plus2 = pc_q + ADDR_W'(2);
  // only the low half of the product is kept
  assign product  = acc_q * opnd;

  assign in_ready_o = (state_q == ST_IDLE);

  // Steer the single memory port
  always_comb begin
    mem_addr  = pc_q;
    mem_we    = 1'b0;
    mem_wdata = acc_q[BYTE_W-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_addr  = ADDR_W'(clr_cnt_q);
        mem_we    = 1'b1;
        mem_wdata = mem_init_byte(clr_cnt_q);
      end
      ST_IDLE: begin
        if (in_valid_i && (action_i == ACT_WRITE)) begin
          mem_addr  = address_i;
          mem_we    = 1'b1;
          mem_wdata = data_i;
        end
      end
      ST_F0:  mem_addr = pc_q + 1'b1;
      ST_F1:  mem_addr = {b0_q[ADDR_W-BYTE_W-1:0], rd_q};
      ST_OP0: mem_addr = arg_q + 1'b1;
      ST_OP1: begin
        if (op == OP_STORE) begin
          mem_addr  = arg_q;
          mem_we    = 1'b1;
          mem_wdata = acc_q[ACC_W-1:BYTE_W];
        end
      end
      ST_ST1: begin
        mem_addr  = arg_q + 1'b1;
        mem_we    = 1'b1;
        mem_wdata = acc_q[BYTE_W-1:0];
      end
      default: mem_addr = pc_q;
    endcase
  end

  // Fold byte addresses onto the memory depth
  assign mem_idx = mem_addr[MEM_AW-1:0];

  // Byte memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_idx] <= mem_wdata;
    end
    rd_q <= mem_q[mem_idx];
  end

  // Launch a divide only for a non-zero divisor
  assign div_start = (state_q == ST_OP1) && (op == OP_DIV) && (opnd != '0);

  acs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (opnd),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // Sequencer, architectural registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      pc_q          <= '0;
      acc_q         <= '0;
      link_q        <= '0;
      b0_q          <= '0;
      arg_q         <= '0;
      opnd_hi_q     <= '0;
      exec_op_q     <= '0;
      div_err_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_pc_q      <= '0;
      out_acc_q     <= '0;
      out_halted_q  <= 1'b0;
      out_op_q      <= '0;
      out_div_err_q <= 1'b0;
    end else begin
      // drop the result word once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            exec_op_q <= '0;
            div_err_q <= 1'b0;
            case (action_i)
              ACT_START: begin
                pc_q    <= address_i;
                link_q  <= '0;
                state_q <= ST_HALT_RD;
              end
              ACT_STEP: state_q <= ST_F0;
              default:  state_q <= ST_HALT_RD;
            endcase
          end
        end
        ST_F0: begin
          // a stopped program does not advance
          if (rd_q[BYTE_W-1:BYTE_W-OP_W] == OP_STOP) begin
            state_q <= ST_HALT_RD;
          end else begin
            b0_q    <= rd_q;
            state_q <= ST_F1;
          end
        end
        ST_F1: begin
          arg_q   <= {b0_q[ADDR_W-BYTE_W-1:0], rd_q};
          state_q <= ST_OP0;
        end
        ST_OP0: begin
          opnd_hi_q <= rd_q;
          state_q   <= ST_OP1;
        end
        ST_OP1: begin
          exec_op_q <= op;
          pc_q      <= pc_plus2;
          state_q   <= ST_HALT_RD;
          case (op)
            OP_JMP:  pc_q <= arg_q;
            OP_JZ:   if (acc_q == '0) pc_q <= arg_q;
            OP_JN:   if (acc_q[ACC_W-1]) pc_q <= arg_q;
            OP_ADD:  acc_q <= acc_q + opnd;
            OP_SUB:  acc_q <= acc_q - opnd;
            OP_MUL:  acc_q <= product;
            OP_DIV: begin
              if (opnd == '0) begin
                div_err_q <= 1'b1;
              end else begin
                state_q <= ST_DIV;
              end
            end
            OP_LOAD:  acc_q <= opnd;
            OP_STORE: state_q <= ST_ST1;
            OP_CALL: begin
              link_q <= pc_plus2;
              pc_q   <= opnd[ADDR_W-1:0];
            end
            OP_RET:  pc_q <= link_q;
            default: pc_q <= pc_plus2;
          endcase
        end
        ST_ST1: state_q <= ST_HALT_RD;
        ST_DIV: begin
          if (div_done) begin
            acc_q   <= div_quotient;
            state_q <= ST_HALT_RD;
          end
        end
        ST_HALT_RD: state_q <= ST_FINISH;
        ST_FINISH: begin
          // load the result once the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_pc_q      <= pc_q;
            out_acc_q     <= acc_q;
            out_halted_q  <= (rd_q[BYTE_W-1:BYTE_W-OP_W] == OP_STOP);
            out_op_q      <= exec_op_q;
            out_div_err_q <= div_err_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pc_o              = out_pc_q;
  assign acc_value_o       = $signed(out_acc_q);
  assign halted_o          = out_halted_q;
  assign executed_opcode_o = out_op_q;
  assign div_error_o       = out_div_err_q;

  // A divide-by-zero flag only comes with a divide instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_error_o) |-> (executed_opcode_o == OP_DIV))
    else $error("div_error without a divide opcode");

  // Outside the sweep and host writes, memory is written only by a store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != ST_CLEAR) && (state_q != ST_IDLE)) |-> (op == OP_STORE))
    else $error("memory written outside a store");

  // The divider never sees a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (opnd != '0))
    else $error("divide launched with zero divisor");

  // While waiting on a divide, the divider is working or just finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the accumulator processor step block.
module tb;
  import acs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GAP        = 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_REPORTS    = 50;

  // Codes the package leaves unnamed
  localparam logic [1:0]      ACT_NONE    = 2'd3;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd11;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [ACC_W-1:0]  acc;
    logic              halted;
    logic [OP_W-1:0]   opcode;
    logic              div_err;
  } cpu_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              action_i    = ACT_WRITE;
  logic [ADDR_W-1:0]       address_i   = '0;
  logic [BYTE_W-1:0]       data_i      = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [ADDR_W-1:0]       pc_o;
  logic signed [ACC_W-1:0] acc_value_o;
  logic                    halted_o;
  logic [OP_W-1:0]         executed_opcode_o;
  logic                    div_error_o;

  // Shadow copy of the processor state
  logic [BYTE_W-1:0] shadow_mem [MEM_DEPTH];
  logic [ACC_W-1:0]  shadow_acc;
  logic [ADDR_W-1:0] shadow_pc;
  logic [ADDR_W-1:0] shadow_link;

  cpu_result_t pending_results[$];
  int          err_count     = 0;
  int          results_seen  = 0;
  int          words_sent    = 0;
  int          rx_hold_cycles = 0;
  bit          idle_on       = 1'b1;

  accumulator_cpu_step dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .address_i         (address_i),
    .data_i            (data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pc_o              (pc_o),
    .acc_value_o       (acc_value_o),
    .halted_o          (halted_o),
    .executed_opcode_o (executed_opcode_o),
    .div_error_o       (div_error_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // State predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    for (int i = 0; i < MEM_DEPTH; i++) shadow_mem[i] = '0;
    shadow_mem[8'h0a % MEM_DEPTH] = 8'h01;
    shadow_mem[8'h1a % MEM_DEPTH] = 8'h12;
    shadow_mem[8'h21 % MEM_DEPTH] = 8'h42;
    shadow_mem[8'h3F % MEM_DEPTH] = 8'h20;
    shadow_acc  = '0;
    shadow_pc   = '0;
    shadow_link = '0;
  endfunction

  function automatic logic [BYTE_W-1:0] mem_byte(logic [ADDR_W-1:0] a);
    return shadow_mem[a % MEM_DEPTH];
  endfunction

  // Big-endian operand word; the second byte wraps within 12 bits
  function automatic logic [ACC_W-1:0] mem_word(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] a1;
    a1 = a + 1'b1;
    return {mem_byte(a), mem_byte(a1)};
  endfunction

  function automatic logic stop_at(logic [ADDR_W-1:0] a);
    logic [BYTE_W-1:0] b;
    b = mem_byte(a);
    return b[7:4] == OP_STOP;
  endfunction

  // Apply one input word to the shadow state and return the result it yields
  function automatic cpu_result_t apply_word(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                             logic [BYTE_W-1:0] dat);
    cpu_result_t       r;
    logic [BYTE_W-1:0] b0, b1;
    logic [ADDR_W-1:0] pc1, arg, arg1, next_pc;
    logic [ACC_W-1:0]  opnd;
    int                num, den;
    r = '0;
    if (act == ACT_WRITE) begin
      shadow_mem[addr % MEM_DEPTH] = dat;
    end else if (act == ACT_START) begin
      shadow_pc   = addr;
      shadow_link = '0;
    end else if (act == ACT_STEP && !stop_at(shadow_pc)) begin
      pc1     = shadow_pc + 1'b1;
      b0      = mem_byte(shadow_pc);
      b1      = mem_byte(pc1);
      arg     = {b0[3:0], b1};
      arg1    = arg + 1'b1;
      opnd    = mem_word(arg);
      next_pc = shadow_pc + 12'd2;
      r.opcode = b0[7:4];
      case (opcode_e'(b0[7:4]))
        OP_JMP:   next_pc = arg;
        OP_JZ:    if (shadow_acc == '0) next_pc = arg;
        OP_JN:    if (shadow_acc[ACC_W-1]) next_pc = arg;
        OP_ADD:   shadow_acc = shadow_acc + opnd;
        OP_SUB:   shadow_acc = shadow_acc - opnd;
        OP_MUL:   shadow_acc = shadow_acc * opnd;
        OP_DIV: begin
          // Signed quotient truncated toward zero; a zero divisor leaves acc alone
          if (opnd == '0) begin
            r.div_err = 1'b1;
          end else begin
            num = $signed(shadow_acc);
            den = $signed(opnd);
            shadow_acc = ACC_W'(num / den);
          end
        end
        OP_LOAD:  shadow_acc = opnd;
        OP_STORE: begin
          shadow_mem[arg % MEM_DEPTH]  = shadow_acc[15:8];
          shadow_mem[arg1 % MEM_DEPTH] = shadow_acc[7:0];
        end
        OP_CALL: begin
          shadow_link = next_pc;
          next_pc     = opnd[ADDR_W-1:0];
        end
        OP_RET:   next_pc = shadow_link;
        default: ;
      endcase
      shadow_pc = next_pc;
    end
    r.pc     = shadow_pc;
    r.acc    = shadow_acc;
    r.halted = stop_at(shadow_pc);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
  endtask

  // Predict on every accepted input word, then compare every accepted result word
  always @(posedge clk_i) begin
    cpu_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        pending_results.push_back(apply_word(action_i, address_i, data_i));
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending, pc %0h", pc_o));
        end else begin
          want = pending_results.pop_front();
          check_field("pc", 32'(pc_o), 32'(want.pc));
          check_field("acc_value", 32'($unsigned(acc_value_o)), 32'(want.acc));
          check_field("halted", 32'(halted_o), 32'(want.halted));
          check_field("executed_opcode", 32'(executed_opcode_o), 32'(want.opcode));
          check_field("div_error", 32'(div_error_o), 32'(want.div_err));
        end
        results_seen++;
      end
    end
  end

  // Drop ready for a random gap per result word, plus any long hold requested
  initial begin : result_sink
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_n = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      wait_n += rx_hold_cycles;
      rx_hold_cycles = 0;
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // End the run when no word moves on either side for too long
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
      else stalled++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(logic [1:0] act, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] dat);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    address_i  <= addr;
    data_i     <= dat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic put_word(logic [ADDR_W-1:0] addr, logic [ACC_W-1:0] w);
    logic [ADDR_W-1:0] a1;
    a1 = addr + 1'b1;
    send_word(ACT_WRITE, addr, w[15:8]);
    send_word(ACT_WRITE, a1, w[7:0]);
  endtask

  task automatic put_instr(logic [ADDR_W-1:0] addr, logic [OP_W-1:0] op,
                           logic [ADDR_W-1:0] arg);
    put_word(addr, {op, arg});
  endtask

  // Withdraw the last word so it is not taken again, then wait for every result
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Step from reset, the unused action code, and instructions formed by the preset bytes
  task automatic test_reset_presets();
    send_word(ACT_STEP, 12'h000, 8'h00);
    send_word(ACT_NONE, 12'hFFF, 8'hFF);
    send_word(ACT_START, 12'h00A, 8'h00);
    send_word(ACT_STEP, 12'h000, 8'h00);
    send_word(ACT_START, 12'h01A, 8'hFF);
    send_word(ACT_STEP, 12'hFFF, 8'hFF);
    send_word(ACT_START, 12'h021, 8'h00);
    send_word(ACT_STEP, 12'h000, 8'h00);
    send_word(ACT_START, 12'h03F, 8'h00);
    send_word(ACT_STEP, 12'h000, 8'h00);
  endtask

  // Fetch and operand read both straddle the top of memory
  task automatic test_wraparound();
    send_word(ACT_WRITE, 12'hFFF, {OP_LOAD, 4'hF});
    send_word(ACT_WRITE, 12'h000, 8'hFF);
    send_word(ACT_START, 12'hFFF, 8'h00);
    send_word(ACT_STEP, 12'h000, 8'h00);
  endtask

  // One pass over every opcode but JMP; argument low bytes are left at zero in memory but the store's
  task automatic test_instruction_set();
    // operands: 0x8000 at 0x300, -1 at 0x500, 7 at 0x700, zero at 0x800, call target at 0x900
    send_word(ACT_WRITE, 12'h300, 8'h80);
    put_word(12'h500, 16'hFFFF);
    send_word(ACT_WRITE, 12'h701, 8'h07);
    send_word(ACT_WRITE, 12'h900, 8'hF4);
    send_word(ACT_WRITE, 12'h100, {OP_LOAD, 4'h3});
    send_word(ACT_WRITE, 12'h102, {OP_JN, 4'h2});
    send_word(ACT_WRITE, 12'h200, {OP_DIV, 4'h5});
    send_word(ACT_WRITE, 12'h202, {OP_SUB, 4'h7});
    send_word(ACT_WRITE, 12'h204, {OP_JN, 4'h1});
    send_word(ACT_WRITE, 12'h206, {OP_MUL, 4'h3});
    send_word(ACT_WRITE, 12'h208, {OP_DIV, 4'h8});
    send_word(ACT_WRITE, 12'h20A, {OP_ADD, 4'h7});
    send_word(ACT_WRITE, 12'h20C, {OP_DIV, 4'h7});
    put_instr(12'h20E, OP_STORE, 12'hFFF);
    send_word(ACT_WRITE, 12'h210, {OP_CALL, 4'h9});
    send_word(ACT_WRITE, 12'h212, {OP_STOP, 4'h0});
    send_word(ACT_WRITE, 12'h400, {OP_JZ, 4'h1});
    send_word(ACT_WRITE, 12'h402, {OP_LOAD, 4'h8});
    send_word(ACT_WRITE, 12'h404, {OP_JZ, 4'h6});
    send_word(ACT_WRITE, 12'h600, {OP_SPARE_LO, 4'h0});
    send_word(ACT_WRITE, 12'h602, {OP_SPARE_HI, 4'h0});
    send_word(ACT_WRITE, 12'h604, {OP_RET, 4'h0});
    send_word(ACT_START, 12'h100, 8'h00);
    // seventeen instructions to the stop, then one step while stopped
    repeat (18) send_word(ACT_STEP, 12'($urandom), 8'($urandom));
  endtask

  // Hold the result side off while words keep coming, then let everything drain
  task automatic test_backpressure();
    idle_on = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    repeat (24) send_word(ACT_WRITE, 12'($urandom), 8'($urandom));
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  // Short random programs with their data, run with start and steps; some noise between
  task automatic test_random_programs();
    int                first_word, round, k, n;
    logic [ADDR_W-1:0] base, dbase, arg, target;
    logic [OP_W-1:0]   op;
    logic [ACC_W-1:0]  val;
    logic [1:0]        act;
    first_word = words_sent;
    round = 0;
    while (words_sent - first_word < RANDOM_WORDS) begin
      idle_on = (round % 8 != 5);
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(3, 12);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0:       act = ACT_NONE;
            1, 2:    act = ACT_START;
            3, 4, 5: act = ACT_STEP;
            default: act = ACT_WRITE;
          endcase
          send_word(act, 12'($urandom), 8'($urandom));
        end
      end else begin
        base  = 12'($urandom);
        dbase = 12'($urandom);
        k     = $urandom_range(2, 8);
        // first data word holds a call target inside the program
        target = base + 12'(2 * $urandom_range(0, k - 1));
        put_word(dbase, {4'($urandom), target});
        for (int i = 1; i < 4; i++) begin
          case ($urandom_range(0, 7))
            0:       val = 16'h0000;
            1:       val = 16'h8000;
            2:       val = 16'hFFFF;
            3:       val = 16'h7FFF;
            4:       val = 16'h0001;
            default: val = 16'($urandom);
          endcase
          put_word(dbase + 12'(2 * i), val);
        end
        for (int i = 0; i < k; i++) begin
          op = 4'($urandom);
          if (i == k - 1 && $urandom_range(0, 1) == 1) op = OP_STOP;
          case (op)
            OP_JMP, OP_JZ, OP_JN: arg = base + 12'(2 * $urandom_range(0, k - 1));
            OP_CALL:              arg = dbase;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOAD, OP_STORE:
              arg = ($urandom_range(0, 5) == 0) ? 12'($urandom)
                                                : dbase + 12'(2 * $urandom_range(0, 3));
            default:              arg = 12'($urandom);
          endcase
          put_instr(base + 12'(2 * i), op, arg);
        end
        send_word(ACT_START, base, 8'($urandom));
        n = k + $urandom_range(0, 6);
        repeat (n) send_word(ACT_STEP, 12'($urandom), 8'($urandom));
      end
      // pause the sender now and then until every result is back
      if (round % 16 == 9) wait_results_drained();
      round++;
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_presets();
    test_wraparound();
    test_instruction_set();
    test_backpressure();
    test_random_programs();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
